// ===== rtl/cwr_pkg.sv =====
// ----------------------------------------------------------------------------
// cwr_pkg: shared types and constants for the cylinder wall reflect unit
// Word widths, pipeline depths and the side payloads of the sqrt and divider.
// ----------------------------------------------------------------------------
package cwr_pkg;

  localparam int DATA_W        = 32;
  localparam int CFG_W         = 31;
  localparam int IDX_W         = 1;
  localparam int NUM_AX        = 3;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TDATA_W       = 3 * NUM_AX * DATA_W;
  localparam int WIDE_W        = 64;
  localparam int RAD_W         = 2 * WIDE_W;
  localparam int ROOT_W        = WIDE_W;
  localparam int SQRT_STEPS    = ROOT_W;
  localparam int NUM_W         = 96;
  localparam int DIV_STEPS     = 35;

  typedef enum logic [IDX_W-1:0] {
    REG_WALL_RADIUS = 1'b0,
    REG_TIME_STEP   = 1'b1
  } reg_idx_t;

  typedef logic [DATA_W-1:0] word_t;

  // position in the lowest bits, force in the highest
  typedef struct packed {
    word_t [NUM_AX-1:0] f;
    word_t [NUM_AX-1:0] v;
    word_t [NUM_AX-1:0] p;
  } pvf_t;

  typedef struct packed {
    pvf_t                           pvf;
    logic [NUM_AX-1:0]              dneg;
    logic [NUM_AX-1:0][DATA_W-1:0]  m;
    logic [WIDE_W-1:0]              bm;
    logic [WIDE_W-1:0]              a;
    logic                           bneg;
    logic                           refl;
    logic                           err;
    logic                           last;
  } sq_side_t;

  typedef struct packed {
    pvf_t              pvf;
    logic [NUM_AX-1:0] same;
    logic [NUM_AX-1:0] ovf;
    logic              refl;
    logic              err;
    logic              last;
  } dv_side_t;

endpackage

// ===== rtl/cylinder_wall_reflect_unit.sv =====
// ----------------------------------------------------------------------------
// cylinder_wall_reflect_unit: particle reflection off a z-axis cylinder wall
// Traces an outside group member back to the wall crossing and mirrors it.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one particle per transaction: position, velocity and force in
//   s_tdata, the group-member bit in s_tuser, the last-particle mark in s_tlast.
//   m_* carries one result per particle, in order: updated position, velocity
//   and force in m_tdata, {error_flag, reflected} in m_tuser, the mark on
//   m_tlast. The user writes wall_radius (index 0) and time_step (index 1)
//   through cfg_we/cfg_index/cfg_data while no particle is in flight; unchecked.
// Throughput: one particle per cycle while the output is not stalled. The
//   result reaches the output register through 8 front stages, the
//   64-stage square root (one root bit per stage), 4 mid stages, the
//   35-stage divider (one quotient bit per stage) and the output stage.
// Stall: the whole pipeline advances on one enable; while the output result
//   is not taken, every stage holds and s_tready is low. s_tready stays high
//   while the output register is empty or being taken.
// Reset: valid bits and both registers clear; no result is pending.
// ----------------------------------------------------------------------------
module cylinder_wall_reflect_unit #(
  parameter int FRAC_BITS = cwr_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, force_x, force_y, force_z
  input  logic [cwr_pkg::TDATA_W-1:0] s_tdata,
  // in_group
  input  logic                        s_tuser,
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // new_pos_x/y/z, new_vel_x/y/z, new_force_x/y/z
  output logic [cwr_pkg::TDATA_W-1:0] m_tdata,
  // reflected, error_flag
  output logic [1:0]                  m_tuser,
  output logic                        m_tlast,
  input  logic                        cfg_we,
  input  logic [cwr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cwr_pkg::CFG_W-1:0]   cfg_data
);
  import cwr_pkg::*;

  localparam int SUM_W = DIV_STEPS + 2;
  localparam logic [DIV_STEPS-1:0] DISP_MAX = {1'b1, {(DIV_STEPS-1){1'b0}}};
  localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W-1:0] sat_vd(input logic [2*DATA_W-2:0] x);
    if (x[2*DATA_W-2:DATA_W-1] == {DATA_W{x[2*DATA_W-2]}}) begin
      return x[DATA_W-1:0];
    end else begin
      return x[2*DATA_W-2] ? WORD_MIN : WORD_MAX;
    end
  endfunction

  function automatic logic [DATA_W-1:0] sat_sum(input logic [SUM_W-1:0] x);
    if (x[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){x[SUM_W-1]}}) begin
      return x[DATA_W-1:0];
    end else begin
      return x[SUM_W-1] ? WORD_MIN : WORD_MAX;
    end
  endfunction

  function automatic logic [DATA_W-1:0] neg_sat(input logic [DATA_W-1:0] x);
    return (x == WORD_MIN) ? WORD_MAX : (~x + 1'b1);
  endfunction

  logic en;
  logic [CFG_W-1:0] wall_radius;
  logic [CFG_W-1:0] time_step;
  pvf_t in_pvf;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign in_pvf   = pvf_t'(s_tdata);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wall_radius <= '0;
      time_step   <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WALL_RADIUS: wall_radius <= cfg_data;
        REG_TIME_STEP:   time_step   <= cfg_data;
      endcase
    end
  end

  // stage registers
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld, h_vld;
  logic i_vld, j_vld, k_vld, l_vld;
  logic sq_vld, dv_vld;

  pvf_t a_pvf, b_pvf, c_pvf, d_pvf, e_pvf, f_pvf, g_pvf;
  logic a_grp, a_last, b_last, c_last, d_last, e_last, f_last, g_last;
  logic b_out, c_out, d_out, e_out, f_out, g_out;

  logic [WIDE_W-1:0]         a_pp [2];
  logic signed [2*DATA_W-2:0] a_vd [NUM_AX];
  logic [2*CFG_W-1:0]        a_r2;

  logic [WIDE_W-1:0]         b_c;
  logic signed [DATA_W-1:0]  b_d [NUM_AX];

  logic [WIDE_W-1:0]         c_c, d_c, e_c;
  logic [WIDE_W-1:0]         c_dd [2];
  logic [WIDE_W-1:0]         c_pd [2];
  logic [NUM_AX-1:0][DATA_W-1:0] c_m, d_m, e_m, f_m, g_m;
  logic [NUM_AX-1:0]         c_dneg, d_dneg, e_dneg, f_dneg, g_dneg;

  logic [WIDE_W-1:0]         d_a, e_a, f_a, g_a;
  logic [WIDE_W:0]           d_b;

  logic [WIDE_W-1:0]         e_bm, f_bm, g_bm;
  logic                      e_bneg, f_bneg, g_bneg;
  logic                      e_az, f_az, g_az;

  logic [WIDE_W-1:0]         f_sq_ll, f_sq_lh, f_sq_hh;
  logic [WIDE_W-1:0]         f_ac_ll, f_ac_lh, f_ac_hl, f_ac_hh;

  logic [RAD_W-1:0]          g_bb, g_ac;
  logic [RAD_W:0]            g_diff;

  logic [RAD_W-1:0]          h_rad;
  sq_side_t                  h_side;

  logic [ROOT_W-1:0]         sq_root;
  sq_side_t                  sq_side;

  logic [WIDE_W-1:0]         i_n;
  sq_side_t                  i_side, j_side, k_side;

  logic [DATA_W+WIDE_W/2:0]  j_pl [NUM_AX];
  logic [DATA_W+WIDE_W/2:0]  j_ph [NUM_AX];

  logic [NUM_AX-1:0][NUM_W-1:0] k_num, l_num;
  logic [WIDE_W-1:0]         l_a;
  dv_side_t                  l_side;

  logic [NUM_AX-1:0][DIV_STEPS-1:0] dv_quot;
  dv_side_t                  dv_side;

  // radial test over the a_* sums
  logic [WIDE_W:0] rr_diff;
  assign rr_diff = {1'b0, a_pp[0] + a_pp[1]} - {{(WIDE_W+1-2*CFG_W){1'b0}}, a_r2};
  assign g_diff  = {1'b0, g_bb} - {1'b0, g_ac};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; b_vld <= 1'b0; c_vld <= 1'b0; d_vld <= 1'b0;
      e_vld <= 1'b0; f_vld <= 1'b0; g_vld <= 1'b0; h_vld <= 1'b0;
      i_vld <= 1'b0; j_vld <= 1'b0; k_vld <= 1'b0; l_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
      b_vld <= a_vld; c_vld <= b_vld; d_vld <= c_vld; e_vld <= d_vld;
      f_vld <= e_vld; g_vld <= f_vld; h_vld <= g_vld;
      i_vld <= sq_vld; j_vld <= i_vld; k_vld <= j_vld; l_vld <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A: squares of x and y, displacement products, r squared
      a_pvf  <= in_pvf;
      a_grp  <= s_tuser;
      a_last <= s_tlast;
      for (int k = 0; k < 2; k++) begin
        a_pp[k] <= $signed(in_pvf.p[k]) * $signed(in_pvf.p[k]);
      end
      for (int k = 0; k < NUM_AX; k++) begin
        a_vd[k] <= $signed(in_pvf.v[k]) * $signed({1'b0, time_step});
      end
      a_r2 <= wall_radius * wall_radius;

      // B: outside test, step displacement d = v*dt floored and saturated
      b_pvf  <= a_pvf;
      b_last <= a_last;
      b_out  <= a_grp && !rr_diff[WIDE_W] && (rr_diff[WIDE_W-1:0] != '0);
      b_c    <= rr_diff[WIDE_W-1:0];
      for (int k = 0; k < NUM_AX; k++) begin
        b_d[k] <= sat_vd(a_vd[k] >>> FRAC_BITS);
      end

      // C: quadratic products, magnitudes of d
      c_pvf  <= b_pvf;
      c_last <= b_last;
      c_out  <= b_out;
      c_c    <= b_c;
      for (int k = 0; k < 2; k++) begin
        c_dd[k] <= b_d[k] * b_d[k];
        c_pd[k] <= $signed(b_pvf.p[k]) * b_d[k];
      end
      for (int k = 0; k < NUM_AX; k++) begin
        c_dneg[k] <= b_d[k][DATA_W-1];
        c_m[k]    <= b_d[k][DATA_W-1] ? (~b_d[k] + 1'b1) : b_d[k];
      end

      // D: a and B sums
      d_pvf  <= c_pvf;
      d_last <= c_last;
      d_out  <= c_out;
      d_c    <= c_c;
      d_m    <= c_m;
      d_dneg <= c_dneg;
      d_a    <= c_dd[0] + c_dd[1];
      d_b    <= {c_pd[0][WIDE_W-1], c_pd[0]} + {c_pd[1][WIDE_W-1], c_pd[1]};

      // E: |B|, no-radial-motion flag
      e_pvf  <= d_pvf;
      e_last <= d_last;
      e_out  <= d_out;
      e_c    <= d_c;
      e_m    <= d_m;
      e_dneg <= d_dneg;
      e_a    <= d_a;
      e_az   <= (d_a == '0);
      e_bneg <= d_b[WIDE_W];
      e_bm   <= d_b[WIDE_W] ? (~d_b[WIDE_W-1:0] + 1'b1) : d_b[WIDE_W-1:0];

      // F: 32x32 partial products of B*B and a*c
      f_pvf   <= e_pvf;
      f_last  <= e_last;
      f_out   <= e_out;
      f_m     <= e_m;
      f_dneg  <= e_dneg;
      f_a     <= e_a;
      f_az    <= e_az;
      f_bm    <= e_bm;
      f_bneg  <= e_bneg;
      f_sq_ll <= e_bm[WIDE_W/2-1:0] * e_bm[WIDE_W/2-1:0];
      f_sq_lh <= e_bm[WIDE_W/2-1:0] * e_bm[WIDE_W-1:WIDE_W/2];
      f_sq_hh <= e_bm[WIDE_W-1:WIDE_W/2] * e_bm[WIDE_W-1:WIDE_W/2];
      f_ac_ll <= e_a[WIDE_W/2-1:0] * e_c[WIDE_W/2-1:0];
      f_ac_lh <= e_a[WIDE_W/2-1:0] * e_c[WIDE_W-1:WIDE_W/2];
      f_ac_hl <= e_a[WIDE_W-1:WIDE_W/2] * e_c[WIDE_W/2-1:0];
      f_ac_hh <= e_a[WIDE_W-1:WIDE_W/2] * e_c[WIDE_W-1:WIDE_W/2];

      // G: assemble B*B and a*c
      g_pvf  <= f_pvf;
      g_last <= f_last;
      g_out  <= f_out;
      g_m    <= f_m;
      g_dneg <= f_dneg;
      g_a    <= f_a;
      g_az   <= f_az;
      g_bm   <= f_bm;
      g_bneg <= f_bneg;
      g_bb   <= {f_sq_hh, {WIDE_W{1'b0}}}
              + {{(WIDE_W/2-1){1'b0}}, f_sq_lh, {(WIDE_W/2+1){1'b0}}}
              + {{WIDE_W{1'b0}}, f_sq_ll};
      g_ac   <= {f_ac_hh, {WIDE_W{1'b0}}}
              + {{(WIDE_W/2){1'b0}}, f_ac_lh, {(WIDE_W/2){1'b0}}}
              + {{(WIDE_W/2){1'b0}}, f_ac_hl, {(WIDE_W/2){1'b0}}}
              + {{WIDE_W{1'b0}}, f_ac_ll};

      // H: discriminant and the reflect / error decision
      h_rad         <= g_diff[RAD_W-1:0];
      h_side.pvf    <= g_pvf;
      h_side.dneg   <= g_dneg;
      h_side.m      <= g_m;
      h_side.bm     <= g_bm;
      h_side.a      <= g_a;
      h_side.bneg   <= g_bneg;
      h_side.refl   <= g_out && !g_az && !g_diff[RAD_W];
      h_side.err    <= g_out && (g_az || g_diff[RAD_W]);
      h_side.last   <= g_last;

      // I: n = |B| - sqrt(D)
      i_side <= sq_side;
      i_n    <= sq_side.bm - sq_root;

      // J: 2*|d|*n partial products
      j_side <= i_side;
      for (int k = 0; k < NUM_AX; k++) begin
        j_pl[k] <= {i_side.m[k], 1'b0} * i_n[WIDE_W/2-1:0];
        j_ph[k] <= {i_side.m[k], 1'b0} * i_n[WIDE_W-1:WIDE_W/2];
      end

      // K: dividend assembly
      k_side <= j_side;
      for (int k = 0; k < NUM_AX; k++) begin
        k_num[k] <= NUM_W'({j_ph[k], {(WIDE_W/2){1'b0}}}
                         + {{(WIDE_W/2){1'b0}}, j_pl[k]});
      end

      // L: quotient overflow check ahead of the divider
      l_num         <= k_num;
      l_a           <= k_side.a;
      l_side.pvf    <= k_side.pvf;
      l_side.same   <= ~(k_side.dneg ^ {NUM_AX{k_side.bneg}});
      l_side.refl   <= k_side.refl;
      l_side.err    <= k_side.err;
      l_side.last   <= k_side.last;
      for (int k = 0; k < NUM_AX; k++) begin
        l_side.ovf[k] <= {{(WIDE_W-(NUM_W-DIV_STEPS)){1'b0}},
                          k_num[k][NUM_W-1:DIV_STEPS]} >= k_side.a;
      end
    end
  end

  cwr_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (h_vld),
    .radicand  (h_rad),
    .in_side   (h_side),
    .out_valid (sq_vld),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  cwr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (l_vld),
    .den       (l_a),
    .num       (l_num),
    .in_side   (l_side),
    .out_valid (dv_vld),
    .quot      (dv_quot),
    .out_side  (dv_side)
  );

  // final: clamp the mirror distance; if reflected, move p and flip v and f
  pvf_t out_pvf;

  always_comb begin
    logic [DIV_STEPS-1:0] disp;
    logic [SUM_W-1:0]     ps;
    logic [SUM_W-1:0]     ds;
    out_pvf = dv_side.pvf;
    for (int k = 0; k < NUM_AX; k++) begin
      disp = (dv_side.ovf[k] || dv_quot[k][DIV_STEPS-1]) ? DISP_MAX : dv_quot[k];
      ps   = {{(SUM_W-DATA_W){dv_side.pvf.p[k][DATA_W-1]}}, dv_side.pvf.p[k]};
      ds   = {2'b00, disp};
      if (dv_side.refl) begin
        out_pvf.p[k] = sat_sum(dv_side.same[k] ? (ps - ds) : (ps + ds));
        out_pvf.v[k] = neg_sat(dv_side.pvf.v[k]);
        out_pvf.f[k] = neg_sat(dv_side.pvf.f[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= out_pvf;
      m_tuser <= {dv_side.err, dv_side.refl};
      m_tlast <= dv_side.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("reflected and error_flag both set");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending right after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(h_rad) && $stable(b_c))
    else $error("pipeline moved during output stall");
`endif

endmodule

// ===== rtl/cwr_isqrt.sv =====
// ----------------------------------------------------------------------------
// cwr_isqrt: pipelined integer square root
// One root bit per stage, restoring digit recurrence, side payload in step.
// ----------------------------------------------------------------------------
module cwr_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [cwr_pkg::RAD_W-1:0] radicand,
  input  cwr_pkg::sq_side_t         in_side,
  output logic                      out_valid,
  output logic [cwr_pkg::ROOT_W-1:0] root,
  output cwr_pkg::sq_side_t         out_side
);
  import cwr_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [SQRT_STEPS-1:0] vld_q;
  logic [REM_W-1:0]      rem_q     [SQRT_STEPS];
  logic [REM_W-1:0]      rem_next  [SQRT_STEPS];
  logic [ROOT_W-1:0]     root_q    [SQRT_STEPS];
  logic [ROOT_W-1:0]     root_next [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_q     [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_next  [SQRT_STEPS];
  sq_side_t              side_q    [SQRT_STEPS];

  function automatic logic [REM_W+ROOT_W-1:0] sq_step(input logic [REM_W-1:0] rem,
                                                      input logic [ROOT_W-1:0] rt,
                                                      input logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    cur   = {rem[REM_W-3:0], pair};
    trial = {1'b0, rt, 2'b01};
    if (cur >= trial) begin
      return {cur - trial, rt[ROOT_W-2:0], 1'b1};
    end else begin
      return {cur, rt[ROOT_W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    {rem_next[0], root_next[0]} = sq_step('0, '0, radicand[RAD_W-1 -: 2]);
    rad_next[0] = radicand << 2;
    for (int s = 1; s < SQRT_STEPS; s++) begin
      {rem_next[s], root_next[s]} = sq_step(rem_q[s-1], root_q[s-1],
                                            rad_q[s-1][RAD_W-1 -: 2]);
      rad_next[s] = rad_q[s-1] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[SQRT_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int s = 0; s < SQRT_STEPS; s++) begin
        rem_q[s]  <= rem_next[s];
        root_q[s] <= root_next[s];
        rad_q[s]  <= rad_next[s];
      end
      for (int s = 1; s < SQRT_STEPS; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign out_valid = vld_q[SQRT_STEPS-1];
  assign root      = root_q[SQRT_STEPS-1];
  assign out_side  = side_q[SQRT_STEPS-1];

endmodule

// ===== rtl/cwr_div.sv =====
// ----------------------------------------------------------------------------
// cwr_div: pipelined restoring divider, one lane per axis
// One quotient bit per stage; all lanes share the divisor and side payload.
// ----------------------------------------------------------------------------
module cwr_div (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   en,
  input  logic                                                   in_valid,
  input  logic [cwr_pkg::WIDE_W-1:0]                             den,
  input  logic [cwr_pkg::NUM_AX-1:0][cwr_pkg::NUM_W-1:0]         num,
  input  cwr_pkg::dv_side_t                                      in_side,
  output logic                                                   out_valid,
  output logic [cwr_pkg::NUM_AX-1:0][cwr_pkg::DIV_STEPS-1:0]     quot,
  output cwr_pkg::dv_side_t                                      out_side
);
  import cwr_pkg::*;

  localparam int PAD_W = WIDE_W - (NUM_W - DIV_STEPS);

  logic [DIV_STEPS-1:0] vld_q;
  logic [WIDE_W-1:0]    den_q   [DIV_STEPS];
  dv_side_t             side_q  [DIV_STEPS];
  logic [WIDE_W-1:0]    rem_q   [DIV_STEPS][NUM_AX];
  logic [WIDE_W-1:0]    rem_nx  [DIV_STEPS][NUM_AX];
  logic [DIV_STEPS-1:0] low_q   [DIV_STEPS][NUM_AX];
  logic [DIV_STEPS-1:0] low_nx  [DIV_STEPS][NUM_AX];
  logic [DIV_STEPS-1:0] q_q     [DIV_STEPS][NUM_AX];
  logic [DIV_STEPS-1:0] q_nx    [DIV_STEPS][NUM_AX];

  function automatic logic [WIDE_W:0] dv_step(input logic [WIDE_W-1:0] rem,
                                              input logic b,
                                              input logic [WIDE_W-1:0] d);
    logic [WIDE_W:0] cur;
    logic [WIDE_W:0] diff;
    cur  = {rem, b};
    diff = cur - {1'b0, d};
    if (cur >= {1'b0, d}) begin
      return {diff[WIDE_W-1:0], 1'b1};
    end else begin
      return {cur[WIDE_W-1:0], 1'b0};
    end
  endfunction

  always_comb begin
    logic [WIDE_W:0] r;
    for (int k = 0; k < NUM_AX; k++) begin
      r = dv_step({{PAD_W{1'b0}}, num[k][NUM_W-1:DIV_STEPS]},
                  num[k][DIV_STEPS-1], den);
      rem_nx[0][k] = r[WIDE_W:1];
      q_nx[0][k]   = {{(DIV_STEPS-1){1'b0}}, r[0]};
      low_nx[0][k] = num[k][DIV_STEPS-1:0] << 1;
      for (int s = 1; s < DIV_STEPS; s++) begin
        r = dv_step(rem_q[s-1][k], low_q[s-1][k][DIV_STEPS-1], den_q[s-1]);
        rem_nx[s][k] = r[WIDE_W:1];
        q_nx[s][k]   = {q_q[s-1][k][DIV_STEPS-2:0], r[0]};
        low_nx[s][k] = low_q[s-1][k] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_q[0]  <= den;
      side_q[0] <= in_side;
      for (int s = 1; s < DIV_STEPS; s++) begin
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
        for (int k = 0; k < NUM_AX; k++) begin
          rem_q[s][k] <= rem_nx[s][k];
          low_q[s][k] <= low_nx[s][k];
          q_q[s][k]   <= q_nx[s][k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AX; k++) begin
      quot[k] = q_q[DIV_STEPS-1][k];
    end
  end

  assign out_valid = vld_q[DIV_STEPS-1];
  assign out_side  = side_q[DIV_STEPS-1];

endmodule
